>>> rtl/core/keypad_four_function_calculator_assert.svh
// ----------------------------------------------------------------------------
// Keypad calculator assertion macros
// Shared concurrent assertion forms, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_ASSERT_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define KFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define KFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define KFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/kfc_pkg.sv
// ----------------------------------------------------------------------------
// Keypad calculator package
// Widths, key and event codes, the scan table and shared helper functions.
// ----------------------------------------------------------------------------
package kfc_pkg;

    // Number of decimal digits an operand may hold (1 to 8).
    localparam int OPERAND_DIGITS = 8;

    localparam int SCAN_W    = 8;
    localparam int KEY_W     = 5;
    localparam int DIGIT_W   = 4;
    localparam int OPERAND_W = 27;
    localparam int APPEND_W  = OPERAND_W + 4;
    localparam int SCALED_W  = 34;
    localparam int VALUE_W   = 61;
    localparam int CNT_W     = 6;
    localparam int MUL_STEPS = OPERAND_W;
    localparam int DIV_STEPS = SCALED_W;

    // Request queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [SCAN_W-1:0]    scan_t;
    typedef logic [KEY_W-1:0]     key_code_t;
    typedef logic [OPERAND_W-1:0] operand_t;

    // Key codes with a meaning of their own.
    localparam key_code_t KEY_DIGIT_MAX = 5'd9;
    localparam key_code_t KEY_DIV       = 5'd10;
    localparam key_code_t KEY_EQUALS    = 5'd14;
    localparam key_code_t KEY_CLEAR     = 5'd15;
    localparam key_code_t KEY_NONE      = 5'd16;

    // Scan byte for each key code, in key order.
    localparam scan_t KEY_SCAN_TABLE [16] = '{
        8'd235, 8'd215, 8'd219, 8'd221, 8'd183, 8'd187, 8'd189, 8'd119,
        8'd123, 8'd125, 8'd126, 8'd190, 8'd222, 8'd238, 8'd237, 8'd231
    };

    typedef enum logic [2:0] {
        EV_DIGIT   = 3'd0,
        EV_OPER    = 3'd1,
        EV_RESULT  = 3'd2,
        EV_DIV_ERR = 3'd3,
        EV_CLEAR   = 3'd4
    } ev_t;

    typedef enum logic [2:0] {
        OP_DIV  = 3'd0,
        OP_MUL  = 3'd1,
        OP_SUB  = 3'd2,
        OP_ADD  = 3'd3,
        OP_NONE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    // One decoded key request moving toward the back part.
    typedef struct packed {
        logic      valid;
        key_code_t code;
    } key_req_t;

    // Largest operand value: OPERAND_DIGITS nines.
    function automatic operand_t calc_operand_limit();
        logic [OPERAND_W:0] lim;
        lim = (OPERAND_W + 1)'(1);
        for (int i = 0; i < OPERAND_DIGITS; i++)
        begin
            lim = (OPERAND_W + 1)'(lim * (OPERAND_W + 1)'(10));
        end
        return OPERAND_W'(lim - (OPERAND_W + 1)'(1));
    endfunction

    localparam operand_t OPERAND_LIMIT = calc_operand_limit();

    // Scan byte to key code; bytes outside the table give KEY_NONE.
    function automatic key_code_t decode_scan(input scan_t scan);
        key_code_t code;
        code = KEY_NONE;
        for (int i = 15; i >= 0; i--)
        begin
            if (KEY_SCAN_TABLE[i] == scan)
            begin
                code = KEY_W'(i);
            end
        end
        return code;
    endfunction

    // Shift a decimal digit into an operand, saturating at all nines.
    function automatic operand_t append_digit(input operand_t v, input logic [DIGIT_W-1:0] d);
        logic [APPEND_W-1:0] n;
        n = (APPEND_W'(v) << 3) + (APPEND_W'(v) << 1) + APPEND_W'(d);
        return (n > APPEND_W'(OPERAND_LIMIT)) ? OPERAND_LIMIT : OPERAND_W'(n);
    endfunction

endpackage

>>> rtl/core/kfc_front.sv
// ----------------------------------------------------------------------------
// Keypad calculator front part
// Accepts scan bytes, decodes them to key codes and pushes them to the queue.
// ----------------------------------------------------------------------------
module kfc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  kfc_pkg::scan_t   scan_code,
    input  logic             q_full,
    output kfc_pkg::key_req_t push_req
);
    import kfc_pkg::*;

    logic      key_valid_reg;
    logic      key_valid_next;
    key_code_t key_code_reg;
    key_code_t key_code_next;
    logic      accept;
    logic      push;

    // The decoded key waits here until the queue has room.
    assign in_stall = key_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = key_valid_reg && !q_full;

    assign push_req.valid = push;
    assign push_req.code  = key_code_reg;

    // A new scan replaces the held key as it leaves, or fills an empty slot.
    always_comb
    begin
        key_valid_next = key_valid_reg;
        key_code_next  = key_code_reg;
        if (accept)
        begin
            key_valid_next = 1'b1;
            key_code_next  = decode_scan(scan_code);
        end
        else if (push)
        begin
            key_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
        end
        else
        begin
            key_valid_reg <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_code_reg <= key_code_next;
    end

endmodule

>>> rtl/core/kfc_queue.sv
// ----------------------------------------------------------------------------
// Keypad calculator key queue
// Short flip-flop queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`include "keypad_four_function_calculator_assert.svh"

module kfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  kfc_pkg::key_req_t push_req,
    output logic              full,
    output kfc_pkg::key_req_t pop_req,
    input  logic              pop
);
    import kfc_pkg::*;

    key_code_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full          = (count_reg == QCNT_W'(QDEPTH));
    assign pop_req.valid = (count_reg != '0);
    assign pop_req.code  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_req.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_req.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push_req.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_req.valid)
        begin
            entry_reg[wr_ptr_reg] <= push_req.code;
        end
    end

    `KFC_ASSERT_IMP(a_q_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QDEPTH), "queue count overflow")
    `KFC_ASSERT_IMP(a_q_no_push_full, clk, rst_n, push_req.valid, !full, "push into full queue")
    `KFC_ASSERT_IMP(a_q_no_pop_empty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")

endmodule

>>> rtl/core/kfc_back.sv
// ----------------------------------------------------------------------------
// Keypad calculator back part
// Runs the two-phase calculator on queued keys with an iterative multiplier
// and divider, and holds each result in the output register.
// ----------------------------------------------------------------------------
`include "keypad_four_function_calculator_assert.svh"

module kfc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kfc_pkg::key_req_t            pop_req,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   event_res,
    output logic [kfc_pkg::DIGIT_W-1:0]  digit,
    output logic [2:0]                   operator,
    output logic signed [kfc_pkg::VALUE_W-1:0] value
);
    import kfc_pkg::*;

    // Calculator state.
    state_t               state_reg;
    state_t               state_next;
    logic                 phase_reg;
    logic                 phase_next;
    operand_t             a_reg;
    operand_t             a_next;
    operand_t             b_reg;
    operand_t             b_next;
    op_t                  op_reg;
    op_t                  op_next;
    key_code_t            last_key_reg;
    key_code_t            last_key_next;
    logic [VALUE_W-1:0]   last_result_reg;
    logic [VALUE_W-1:0]   last_result_next;

    // Iteration registers.
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [VALUE_W-1:0]   acc_reg;
    logic [VALUE_W-1:0]   acc_next;
    logic [VALUE_W-1:0]   mcand_reg;
    logic [VALUE_W-1:0]   mcand_next;
    operand_t             mplier_reg;
    operand_t             mplier_next;
    logic [OPERAND_W:0]   rem_reg;
    logic [OPERAND_W:0]   rem_next;
    logic [SCALED_W-1:0]  quo_reg;
    logic [SCALED_W-1:0]  quo_next;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    ev_t                  out_event_reg;
    ev_t                  out_event_next;
    logic [DIGIT_W-1:0]   out_digit_reg;
    logic [DIGIT_W-1:0]   out_digit_next;
    op_t                  out_op_reg;
    op_t                  out_op_next;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [VALUE_W-1:0]   out_value_next;

    // Decode and datapath signals.
    key_code_t            code;
    logic                 out_free;
    logic                 take;
    logic                 is_digit;
    logic                 is_clear;
    logic                 is_opkey;
    logic                 is_equals;
    logic                 start_mul;
    logic                 start_div;
    logic [SCALED_W-1:0]  a_scaled;
    logic [VALUE_W-1:0]   lin_operand;
    logic [VALUE_W-1:0]   lin_result;
    logic [OPERAND_W:0]   div_trial;
    logic                 div_fits;
    logic [VALUE_W-1:0]   done_result;

    function automatic logic [VALUE_W-1:0] times_hundred(input logic [VALUE_W-1:0] x);
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

    assign code      = pop_req.code;
    assign out_free  = !out_valid_reg || !out_stall;
    assign take      = (state_reg == ST_IDLE) && pop_req.valid && out_free;
    assign pop       = take;
    assign is_digit  = (code <= KEY_DIGIT_MAX);
    assign is_clear  = (code == KEY_CLEAR);
    assign is_opkey  = (code >= KEY_DIV) && (code <= KEY_EQUALS);
    assign is_equals = (code == KEY_EQUALS);
    assign start_mul = take && phase_reg && is_equals && (op_reg == OP_MUL);
    assign start_div = take && phase_reg && is_equals && (op_reg == OP_DIV) && (b_reg != '0);

    // First operand times one hundred, the multiplicand and the dividend.
    assign a_scaled = (SCALED_W'(a_reg) << 6) + (SCALED_W'(a_reg) << 5)
                    + (SCALED_W'(a_reg) << 2);

    // Subtract and add are computed combinationally.
    assign lin_operand = (op_reg == OP_SUB) ? (VALUE_W'(a_reg) - VALUE_W'(b_reg))
                                            : (VALUE_W'(a_reg) + VALUE_W'(b_reg));
    assign lin_result  = times_hundred(lin_operand);

    // One restoring division step.
    assign div_trial = {rem_reg[OPERAND_W-1:0], quo_reg[SCALED_W-1]};
    assign div_fits  = (div_trial >= {1'b0, b_reg});

    assign done_result = (op_reg == OP_MUL) ? acc_reg : VALUE_W'(quo_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_mul)
                begin
                    state_next = ST_MUL;
                end
                else if (start_div)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_MUL, ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Calculator updates and result requests.
    always_comb
    begin
        phase_next       = phase_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        op_next          = op_reg;
        last_key_next    = last_key_reg;
        last_result_next = last_result_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_event_next   = out_event_reg;
        out_digit_next   = out_digit_reg;
        out_op_next      = out_op_reg;
        out_value_next   = out_value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (!phase_reg)
                    begin
                        // First operand entry: only a change of key counts.
                        if (code != last_key_reg)
                        begin
                            last_key_next = code;
                            if (is_clear)
                            begin
                                a_next           = '0;
                                b_next           = '0;
                                last_result_next = '0;
                                out_valid_next   = 1'b1;
                                out_event_next   = EV_CLEAR;
                                out_digit_next   = '0;
                                out_op_next      = OP_NONE;
                                out_value_next   = '0;
                            end
                            else if (is_digit)
                            begin
                                a_next         = append_digit(a_reg, code[DIGIT_W-1:0]);
                                out_valid_next = 1'b1;
                                out_event_next = EV_DIGIT;
                                out_digit_next = code[DIGIT_W-1:0];
                                out_op_next    = OP_NONE;
                                out_value_next = '0;
                            end
                            else if (is_opkey)
                            begin
                                op_next        = op_t'(3'(code - KEY_DIV));
                                phase_next     = 1'b1;
                                out_valid_next = 1'b1;
                                out_event_next = EV_OPER;
                                out_digit_next = '0;
                                out_op_next    = op_t'(3'(code - KEY_DIV));
                                out_value_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        // Second operand entry: every digit sample counts.
                        if (is_clear)
                        begin
                            a_next           = '0;
                            b_next           = '0;
                            last_result_next = '0;
                            phase_next       = 1'b0;
                            out_valid_next   = 1'b1;
                            out_event_next   = EV_CLEAR;
                            out_digit_next   = '0;
                            out_op_next      = OP_NONE;
                            out_value_next   = '0;
                        end
                        else if (is_digit)
                        begin
                            b_next         = append_digit(b_reg, code[DIGIT_W-1:0]);
                            out_valid_next = 1'b1;
                            out_event_next = EV_DIGIT;
                            out_digit_next = code[DIGIT_W-1:0];
                            out_op_next    = OP_NONE;
                            out_value_next = '0;
                        end
                        else if (is_equals)
                        begin
                            phase_next = 1'b0;
                            case (op_reg)
                                OP_DIV:
                                begin
                                    if (b_reg == '0)
                                    begin
                                        out_valid_next = 1'b1;
                                        out_event_next = EV_DIV_ERR;
                                        out_digit_next = '0;
                                        out_op_next    = OP_DIV;
                                        out_value_next = '0;
                                    end
                                    else
                                    begin
                                        rem_next = '0;
                                        quo_next = a_scaled;
                                        cnt_next = CNT_W'(DIV_STEPS);
                                    end
                                end
                                OP_MUL:
                                begin
                                    acc_next    = '0;
                                    mcand_next  = VALUE_W'(a_scaled);
                                    mplier_next = b_reg;
                                    cnt_next    = CNT_W'(MUL_STEPS);
                                end
                                OP_SUB, OP_ADD:
                                begin
                                    last_result_next = lin_result;
                                    out_valid_next   = 1'b1;
                                    out_event_next   = EV_RESULT;
                                    out_digit_next   = '0;
                                    out_op_next      = op_reg;
                                    out_value_next   = lin_result;
                                end
                                default:
                                begin
                                    // No operator: repeat the last result.
                                    out_valid_next = 1'b1;
                                    out_event_next = EV_RESULT;
                                    out_digit_next = '0;
                                    out_op_next    = op_reg;
                                    out_value_next = last_result_reg;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_MUL:
            begin
                // One multiplier bit per cycle, least significant first.
                acc_next    = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, most significant first.
                rem_next = div_fits ? (div_trial - {1'b0, b_reg}) : div_trial;
                quo_next = {quo_reg[SCALED_W-2:0], div_fits};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    last_result_next = done_result;
                    out_valid_next   = 1'b1;
                    out_event_next   = EV_RESULT;
                    out_digit_next   = '0;
                    out_op_next      = op_reg;
                    out_value_next   = done_result;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            a_reg           <= '0;
            b_reg           <= '0;
            op_reg          <= OP_DIV;
            last_key_reg    <= '0;
            last_result_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            op_reg          <= op_next;
            last_key_reg    <= last_key_next;
            last_result_reg <= last_result_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Iteration and output payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_event_reg <= out_event_next;
        out_digit_reg <= out_digit_next;
        out_op_reg    <= out_op_next;
        out_value_reg <= out_value_next;
    end

    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign digit     = out_digit_reg;
    assign operator  = out_op_reg;
    assign value     = out_value_reg;

    `KFC_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, b_reg != '0, "divide by zero started")
    `KFC_ASSERT_IMP(a_mul_op, clk, rst_n, state_reg == ST_MUL, op_reg == OP_MUL, "multiply without multiply operator")
    `KFC_ASSERT_NXT(a_loop_end, clk, rst_n, (state_reg == ST_MUL || state_reg == ST_DIV) && cnt_reg == CNT_W'(1), state_reg == ST_DONE, "iteration did not finish")
    `KFC_ASSERT_IMP(a_value_zero, clk, rst_n, out_valid_reg && out_event_reg != EV_RESULT, out_value_reg == '0, "value set on non-result event")

endmodule

>>> rtl/core/keypad_four_function_calculator.sv
// ----------------------------------------------------------------------------
// Four-function keypad calculator
// Turns raw keypad scan bytes into digit, operator, result and clear events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, scan_code) carries one raw 4x4 keypad
//   scan byte per request. The byte is decoded in the front stage and held in
//   a two-entry key queue until the calculator back end takes it.
//   Output channel (out_valid, out_stall, event_res, digit, operator, value)
//   carries zero or one event per scan; repeated keys in first operand entry,
//   operator keys during second operand entry and unknown bytes give none.
//   Digit, operator, clear, add and subtract events pass through the front
//   stage register, the key queue and the output register. Equals with
//   multiply also runs the bit-serial multiplier, and equals with divide the
//   restoring divider, one quotient bit per cycle.
//   Throughput is one scan per cycle except while a multiply or divide runs or out_stall holds the output.
//   Reset clears both operands, the phase, the pending operator, the last key
//   and the last result, and empties the queue and the output register.
//   While out_stall is high the output request holds, the queue fills and
//   in_stall rises once the front stage holds a key it cannot pass on.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [kfc_pkg::SCAN_W-1:0]         scan_code,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         event_res,
    output logic [kfc_pkg::DIGIT_W-1:0]        digit,
    output logic [2:0]                         operator,
    output logic signed [kfc_pkg::VALUE_W-1:0] value
);
    import kfc_pkg::*;

    key_req_t push_req;
    key_req_t pop_req;
    logic     q_full;
    logic     pop;

    // Scan decode stage.
    kfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_code (scan_code),
        .q_full    (q_full),
        .push_req  (push_req)
    );

    // Key queue.
    kfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (push_req),
        .full     (q_full),
        .pop_req  (pop_req),
        .pop      (pop)
    );

    // Calculator back end.
    kfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_req   (pop_req),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .digit     (digit),
        .operator  (operator),
        .value     (value)
    );

endmodule

>>> bench/tb_keypad_four_function_calculator.sv
// ----------------------------------------------------------------------------
// Keypad calculator testbench
// Drives raw keypad scan bytes into the calculator with random gaps and
// random output stalls, predicts every event in a scoreboard that tracks the
// calculator state, and compares each event field by field.
// ----------------------------------------------------------------------------
module tb_keypad_four_function_calculator;

    import kfc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SCAN_TARGET  = 1750;
    localparam int SETTLE_TICKS = 60;

    // Scan byte of each key, in key order.
    localparam scan_t PAD_SCAN [16] = '{
        8'd235, 8'd215, 8'd219, 8'd221, 8'd183, 8'd187, 8'd189, 8'd119,
        8'd123, 8'd125, 8'd126, 8'd190, 8'd222, 8'd238, 8'd237, 8'd231
    };

    // Largest operand: all nines.
    localparam longint OPND_MAX = longint'(10) ** OPERAND_DIGITS - 1;

    typedef struct {
        ev_t              ev;
        logic [3:0]       dg;
        op_t              op;
        logic [VALUE_W-1:0] val;
    } calc_event_t;

    // Tracks the calculator state and the events still owed by the block.
    class calc_ledger;
        calc_event_t pending_events[$];
        bit          in_second;
        operand_t    lhs;
        operand_t    rhs;
        op_t         held_op;
        key_code_t   prev_key;
        longint      total;
        int          scans;
        int          checked;
        int          faults;
        int          saturations;
        int          kind_seen[5];

        function new();
            in_second = 1'b0;
            lhs       = '0;
            rhs       = '0;
            held_op   = OP_DIV;
            prev_key  = '0;
            total     = 0;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function key_code_t scan_to_key(scan_t s);
            for (int i = 0; i < 16; i++)
            begin
                if (PAD_SCAN[i] == s)
                begin
                    return key_code_t'(i);
                end
            end
            return KEY_NONE;
        endfunction

        function operand_t shift_in(operand_t v, int d);
            longint n;
            n = longint'(v) * 10 + d;
            if (n > OPND_MAX)
            begin
                saturations++;
                return operand_t'(OPND_MAX);
            end
            return operand_t'(n);
        endfunction

        function void post(ev_t ev, logic [3:0] dg, op_t op, longint val);
            calc_event_t e;
            e.ev  = ev;
            e.dg  = dg;
            e.op  = op;
            e.val = val[VALUE_W-1:0];
            pending_events.push_back(e);
            kind_seen[ev]++;
        endfunction

        // Clear wipes the operands and the last result and ends second operand entry, but not the operator.
        function void wipe_values();
            lhs       = '0;
            rhs       = '0;
            total     = 0;
            in_second = 1'b0;
        endfunction

        function void settle_equals();
            longint a;
            longint b;
            a = longint'(lhs);
            b = longint'(rhs);
            case (held_op)
                OP_DIV:
                begin
                    if (b == 0)
                    begin
                        post(EV_DIV_ERR, 4'd0, OP_DIV, 0);
                        return;
                    end
                    total = (a * 100) / b;
                end
                OP_MUL: total = a * b * 100;
                OP_SUB: total = (a - b) * 100;
                OP_ADD: total = (a + b) * 100;
                default: ;
            endcase
            post(EV_RESULT, 4'd0, held_op, total);
        endfunction

        // Advance the calculator by one accepted scan request.
        function void note_scan(scan_t s);
            key_code_t k;
            k = scan_to_key(s);
            scans++;
            if (!in_second)
            begin
                // First operand entry only reacts to a change of key.
                if (k == prev_key)
                begin
                    return;
                end
                prev_key = k;
                if (k == KEY_CLEAR)
                begin
                    wipe_values();
                    post(EV_CLEAR, 4'd0, OP_NONE, 0);
                end
                else if (k <= KEY_DIGIT_MAX)
                begin
                    lhs = shift_in(lhs, int'(k));
                    post(EV_DIGIT, k[3:0], OP_NONE, 0);
                end
                else if (k <= KEY_EQUALS)
                begin
                    held_op   = op_t'(3'(k - KEY_DIV));
                    in_second = 1'b1;
                    post(EV_OPER, 4'd0, held_op, 0);
                end
            end
            else
            begin
                // Second operand entry takes every digit sample.
                if (k == KEY_CLEAR)
                begin
                    wipe_values();
                    post(EV_CLEAR, 4'd0, OP_NONE, 0);
                end
                else if (k <= KEY_DIGIT_MAX)
                begin
                    rhs = shift_in(rhs, int'(k));
                    post(EV_DIGIT, k[3:0], OP_NONE, 0);
                end
                else if (k == KEY_EQUALS)
                begin
                    in_second = 1'b0;
                    settle_equals();
                end
            end
        endfunction

        // Compare one delivered event with the oldest one owed.
        function void check_event(logic [2:0] ev, logic [3:0] dg, logic [2:0] op,
                                  logic [VALUE_W-1:0] val);
            calc_event_t e;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event %0d with no request waiting", ev);
                faults++;
                return;
            end
            e = pending_events.pop_front();
            checked++;
            if (ev !== e.ev)
            begin
                $error("event_res: expected %0d, got %0d", e.ev, ev);
                faults++;
            end
            if (dg !== e.dg)
            begin
                $error("digit: expected %0d, got %0d", e.dg, dg);
                faults++;
            end
            if (op !== e.op)
            begin
                $error("operator: expected %0d, got %0d", e.op, op);
                faults++;
            end
            if (val !== e.val)
            begin
                $error("value: expected %0d, got %0d", $signed(e.val), $signed(val));
                faults++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [SCAN_W-1:0]          scan_code;
    logic                       out_valid;
    logic                       out_stall;
    logic [2:0]                 event_res;
    logic [DIGIT_W-1:0]         digit;
    logic [2:0]                 operator;
    logic signed [VALUE_W-1:0]  value;

    calc_ledger ledger;
    bit         src_calm;
    bit         sink_calm;
    int         sent_count;

    keypad_four_function_calculator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_code (scan_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .digit     (digit),
        .operator  (operator),
        .value     (value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Present one scan request after a random gap and wait for acceptance.
    task automatic send_scan(input scan_t s);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        scan_code <= s;
        do @(posedge clk); while (in_stall);
        ledger.note_scan(s);
        sent_count++;
        if (sent_count % 100 == 0)
        begin
            src_calm = ($urandom_range(0, 3) == 0);
        end
        @(negedge clk);
    endtask

    task automatic press(input key_code_t k);
        send_scan(PAD_SCAN[k[3:0]]);
    endtask

    // Hold the input side until every owed event has been delivered.
    task automatic pause_until_settled();
        in_valid <= 1'b0;
        do @(negedge clk); while (ledger.outstanding() != 0);
    endtask

    // Key in digits, with an occasional stray byte or a held key.
    task automatic enter_digits(input int count);
        key_code_t d;
        repeat (count)
        begin
            d = key_code_t'($urandom_range(0, 9));
            if ($urandom_range(0, 15) == 0)
            begin
                send_scan(scan_t'($urandom_range(0, 255)));
            end
            press(d);
            if ($urandom_range(0, 7) == 0)
            begin
                press(d);
            end
        end
    endtask

    // One full calculation: optional clear, operand, operator, operand, equals.
    task automatic run_calculation();
        int n1;
        int n2;
        int op;
        if ($urandom_range(0, 1) == 1)
        begin
            press(KEY_CLEAR);
        end
        n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        enter_digits(n1);
        op = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3);
        press(key_code_t'(KEY_DIV + op));
        n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        enter_digits(n2);
        press(KEY_EQUALS);
    endtask

    // Output side: random stall before each event, then take it.
    task automatic take_events();
        int hold;
        int taken;
        taken = 0;
        forever
        begin
            hold = sink_calm ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            ledger.check_event(event_res, digit, operator, value);
            taken++;
            if (taken % 100 == 0)
            begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            @(negedge clk);
        end
    endtask

    initial
    begin
        int pick;
        int rounds;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        scan_code = '0;
        out_stall = 1'b0;
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        ledger    = new();
        rounds    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        fork
            take_events();
        join_none

        // Directed part. Digit 0 right after reset is not taken, and bytes
        // outside the table decode to no key.
        press(key_code_t'(0));
        send_scan(8'h00);
        send_scan(8'hff);
        press(key_code_t'(7));
        // Divide with an empty second operand.
        press(KEY_DIV);
        press(KEY_EQUALS);
        press(key_code_t'(KEY_DIV + 3));
        // Nine nines saturate the second operand.
        repeat (9) press(key_code_t'(9));
        // Operator keys do nothing during second operand entry.
        press(key_code_t'(KEY_DIV + 1));
        press(KEY_EQUALS);
        // Equals chosen as the operator repeats the last result.
        press(KEY_EQUALS);
        press(KEY_EQUALS);
        press(KEY_CLEAR);
        press(key_code_t'(KEY_DIV + 2));
        press(key_code_t'(3));
        // Clear during second operand entry keeps the last key taken.
        press(KEY_CLEAR);
        press(key_code_t'(KEY_DIV + 2));
        press(key_code_t'(KEY_DIV + 1));
        pause_until_settled();

        // Random part: mostly full calculations, some noise and stray keys.
        while (ledger.scans < SCAN_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                run_calculation();
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4)) send_scan(scan_t'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) press(key_code_t'($urandom_range(0, 15)));
            end
            rounds++;
            if (rounds % 150 == 0)
            begin
                pause_until_settled();
            end
        end

        // Drain and let the block go quiet.
        in_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Run covered %0d scans and %0d checked events (%0d saturating digits).",
                 ledger.scans, ledger.checked, ledger.saturations);
        $display("Events: digit %0d, operator %0d, result %0d, divide error %0d, clear %0d.",
                 ledger.kind_seen[EV_DIGIT], ledger.kind_seen[EV_OPER],
                 ledger.kind_seen[EV_RESULT], ledger.kind_seen[EV_DIV_ERR],
                 ledger.kind_seen[EV_CLEAR]);
        if (ledger.faults == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
